// File: rtl/core/iarq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iarq_pkg: shared types for the io-aware ready queue
// operation and status codes, slot layout and the controller command bundle
// ----------------------------------------------------------------------------
package iarq_pkg;

  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned TID_W    = 8;
  localparam int unsigned PRI_W    = 8;
  localparam int unsigned DEV_W    = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CNT_W    = 5;

  typedef enum logic [FUNC_W-1:0] {
    OP_PUSH   = 2'd0,
    OP_REMOVE = 2'd1,
    OP_PEEK   = 2'd2,
    OP_WAKE   = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  // one queue slot
  typedef struct packed {
    logic [TID_W-1:0] thread;
    logic [PRI_W-1:0] prio;
    logic             waiting;
    logic [DEV_W-1:0] device;
  } slot_t;

  // controller to datapath
  typedef struct packed {
    logic capture;  // latch the word and compare it against all slots
    logic exec;     // apply the update and load the result register
  } dp_cmd_t;

endpackage

// File: rtl/core/iarq_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iarq channel interfaces
// valid/ready channels for operation words and result words
// ----------------------------------------------------------------------------
interface iarq_in_if;
  logic                         valid;
  logic                         ready;
  logic [iarq_pkg::FUNC_W-1:0]  func;
  logic [iarq_pkg::TID_W-1:0]   thread_id;
  logic [iarq_pkg::PRI_W-1:0]   priority_req;
  logic                         waiting;
  logic [iarq_pkg::DEV_W-1:0]   device;

  modport source (output valid, func, thread_id, priority_req, waiting, device,
                  input ready);
  modport sink (input valid, func, thread_id, priority_req, waiting, device,
                output ready);
endinterface

interface iarq_out_if;
  logic                          valid;
  logic                          ready;
  logic [iarq_pkg::STATUS_W-1:0] status;
  logic [iarq_pkg::TID_W-1:0]    ready_thread;
  logic [iarq_pkg::CNT_W-1:0]    woken_count;
  logic [iarq_pkg::CNT_W-1:0]    occupancy;

  modport source (output valid, status, ready_thread, woken_count, occupancy,
                  input ready);
  modport sink (input valid, status, ready_thread, woken_count, occupancy,
                output ready);
endinterface

// File: rtl/core/io_aware_ready_queue.sv
`timescale 1ns / 1ps
// the result word is registered: a word is captured in idle, then the exec state
//   applies its update and loads the result register; no new word is taken during exec
//   (parallel compare of all slots, then one shift/update of the slot array)
// a result held by out ready low blocks the next word until it drains
// reset: control state and entry count cleared; slot contents stay undefined
//   until pushed, no clearing pass
// ----------------------------------------------------------------------------
// io_aware_ready_queue: priority-sorted thread ready queue with i/o wait marks
// push, remove, peek first ready and wake by device over a shifting slot array
// ----------------------------------------------------------------------------
module io_aware_ready_queue #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic  clk,
  input  logic  rst_n,
  iarq_in_if.sink    in_ch,
  iarq_out_if.source out_ch
);

  iarq_pkg::dp_cmd_t cmd;

  // controller: idle waits for a word, exec runs the update in the following cycle
  iarq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  // datapath: slot array kept in queue order, highest priority at slot 0,
  // equal priorities in arrival order; the result register sits here too
  iarq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_func          (in_ch.func),
    .in_thread_id     (in_ch.thread_id),
    .in_priority_req  (in_ch.priority_req),
    .in_waiting       (in_ch.waiting),
    .in_device        (in_ch.device),
    .out_status       (out_ch.status),
    .out_ready_thread (out_ch.ready_thread),
    .out_woken_count  (out_ch.woken_count),
    .out_occupancy    (out_ch.occupancy)
  );

endmodule

// File: rtl/core/iarq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iarq_ctrl: operation sequencer
// two-state controller that accepts a word, runs its update and owns out valid
// ----------------------------------------------------------------------------
module iarq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output iarq_pkg::dp_cmd_t  cmd
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // the result register is free at exec time if it is empty or drains now
  assign in_ready    = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign cmd.capture = in_valid && in_ready;
  assign cmd.exec    = (state_r == S_EXEC);
  assign out_valid   = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.capture) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: rtl/core/iarq_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iarq_datapath: sorted slot array with parallel compare and shift
// per-slot match vectors on capture, insert/delete shift and result on exec
// ----------------------------------------------------------------------------
module iarq_datapath #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  iarq_pkg::dp_cmd_t             cmd,
  input  logic [iarq_pkg::FUNC_W-1:0]   in_func,
  input  logic [iarq_pkg::TID_W-1:0]    in_thread_id,
  input  logic [iarq_pkg::PRI_W-1:0]    in_priority_req,
  input  logic                          in_waiting,
  input  logic [iarq_pkg::DEV_W-1:0]    in_device,
  output logic [iarq_pkg::STATUS_W-1:0] out_status,
  output logic [iarq_pkg::TID_W-1:0]    out_ready_thread,
  output logic [iarq_pkg::CNT_W-1:0]    out_woken_count,
  output logic [iarq_pkg::CNT_W-1:0]    out_occupancy
);

  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);

  iarq_pkg::slot_t slot_r   [QUEUE_DEPTH];
  iarq_pkg::slot_t slot_nxt [QUEUE_DEPTH];
  logic [CW-1:0]   count_r, count_nxt;

  // latched operation
  iarq_pkg::op_t   op_r;
  iarq_pkg::slot_t new_r;
  logic [QUEUE_DEPTH-1:0] ge_r;     // live and priority >= new priority
  logic [QUEUE_DEPTH-1:0] match_r;  // live and thread matches
  logic [QUEUE_DEPTH-1:0] rdy_r;    // live and not waiting
  logic [QUEUE_DEPTH-1:0] wake_r;   // live, waiting, device matches

  logic [QUEUE_DEPTH-1:0] live, ge_vec, match_vec, rdy_vec, wake_vec;

  // result register
  iarq_pkg::status_t     status_r, status_nxt;
  logic [iarq_pkg::TID_W-1:0] rthread_r, rthread_nxt;
  logic [iarq_pkg::CNT_W-1:0] woken_r, woken_nxt;
  logic [iarq_pkg::CNT_W-1:0] occ_r, occ_nxt;

  logic                   full;
  logic [QUEUE_DEPTH-1:0] match_low, take, rdy_low;
  logic                   found, any_rdy;
  logic [iarq_pkg::TID_W-1:0] peek_thread;
  logic [CW-1:0]          woken_sum;
  logic [31:0]            woken_wide, occ_wide;

  // per-slot compares against the incoming word
  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cmp
    assign live[g]      = (CW'(g) < count_r);
    assign ge_vec[g]    = live[g] && (slot_r[g].prio >= in_priority_req);
    assign match_vec[g] = live[g] && (slot_r[g].thread == in_thread_id);
    assign rdy_vec[g]   = live[g] && !slot_r[g].waiting;
    assign wake_vec[g]  = live[g] && slot_r[g].waiting && (slot_r[g].device == in_device);
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r           <= iarq_pkg::op_t'(in_func);
      new_r.thread   <= in_thread_id;
      new_r.prio     <= in_priority_req;
      new_r.waiting  <= in_waiting;
      new_r.device   <= in_device;
      ge_r           <= ge_vec;
      match_r        <= match_vec;
      rdy_r          <= rdy_vec;
      wake_r         <= wake_vec;
    end
  end

  assign full = (count_r == FULL_COUNT);

  // first match and every slot after it, as a thermometer
  assign match_low = match_r & (~match_r + 1'b1);
  assign take      = ~match_low + 1'b1;
  assign found     = |match_r;

  assign rdy_low = rdy_r & (~rdy_r + 1'b1);
  assign any_rdy = |rdy_r;

  always_comb begin
    peek_thread = '0;
    woken_sum   = '0;
    for (int k = 0; k < QUEUE_DEPTH; k++) begin
      peek_thread = peek_thread | (slot_r[k].thread & {iarq_pkg::TID_W{rdy_low[k]}});
      woken_sum   = woken_sum + CW'(wake_r[k]);
    end
  end

  // slot updates: sorted order means ge_r is a prefix of the live slots
  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_slot
    iarq_pkg::slot_t dn_s, up_s, slot_upd;
    logic            prev_ge;

    if (g == 0) begin : g_head
      assign dn_s    = new_r;
      assign prev_ge = 1'b1;
    end else begin : g_body
      assign dn_s    = slot_r[g-1];
      assign prev_ge = ge_r[g-1];
    end

    if (g == QUEUE_DEPTH - 1) begin : g_tail
      assign up_s = slot_r[g];
    end else begin : g_mid
      assign up_s = slot_r[g+1];
    end

    always_comb begin
      slot_upd = slot_r[g];
      if (cmd.exec) begin
        case (op_r)
          iarq_pkg::OP_PUSH: begin
            if (!full && !ge_r[g]) slot_upd = prev_ge ? new_r : dn_s;
          end
          iarq_pkg::OP_REMOVE: begin
            if (take[g]) slot_upd = up_s;
          end
          iarq_pkg::OP_WAKE: begin
            if (wake_r[g]) slot_upd.waiting = 1'b0;
          end
          default: ;
        endcase
      end
    end

    assign slot_nxt[g] = slot_upd;
  end

  always_comb begin
    count_nxt   = count_r;
    status_nxt  = iarq_pkg::ST_OK;
    rthread_nxt = '0;
    woken_nxt   = '0;
    woken_wide  = 32'(woken_sum);
    case (op_r)
      iarq_pkg::OP_PUSH: begin
        if (full) status_nxt = iarq_pkg::ST_FULL;
        else      count_nxt  = count_r + 1'b1;
      end
      iarq_pkg::OP_REMOVE: begin
        if (found) count_nxt  = count_r - 1'b1;
        else       status_nxt = iarq_pkg::ST_MISS;
      end
      iarq_pkg::OP_PEEK: begin
        if (any_rdy) rthread_nxt = peek_thread;
        else         status_nxt  = iarq_pkg::ST_MISS;
      end
      iarq_pkg::OP_WAKE: begin
        if (count_r == '0) status_nxt = iarq_pkg::ST_MISS;
        else               woken_nxt  = woken_wide[iarq_pkg::CNT_W-1:0];
      end
      default: ;
    endcase
    occ_wide = 32'(count_nxt);
    occ_nxt  = occ_wide[iarq_pkg::CNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
    if (cmd.exec) begin
      status_r  <= status_nxt;
      rthread_r <= rthread_nxt;
      woken_r   <= woken_nxt;
      occ_r     <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.exec) begin
      count_r <= count_nxt;
    end
  end

  assign out_status       = status_r;
  assign out_ready_thread = rthread_r;
  assign out_woken_count  = woken_r;
  assign out_occupancy    = occ_r;

endmodule

// File: rtl/core/iarq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iarq_checker: port-level checks for the ready queue
// timing of accept and result, stall behavior and result field consistency
// ----------------------------------------------------------------------------
module iarq_checker #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [iarq_pkg::STATUS_W-1:0] out_status,
  input logic [iarq_pkg::TID_W-1:0]    out_ready_thread,
  input logic [iarq_pkg::CNT_W-1:0]    out_woken_count,
  input logic [iarq_pkg::CNT_W-1:0]    out_occupancy
);

  localparam logic [iarq_pkg::CNT_W-1:0] OCC_FULL = iarq_pkg::CNT_W'(QUEUE_DEPTH);

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // one word in flight: no second accept in the exec cycle
  a_no_back_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("word accepted during exec cycle");

  // result shows up once the exec state that follows the accept is done
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> ##2 out_valid)
    else $error("result not presented two cycles after accept");

  // stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_status) &&
      $stable(out_ready_thread) && $stable(out_woken_count) &&
      $stable(out_occupancy)))
    else $error("stalled result changed");

  // a failed operation reports no thread and no wakeups
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != iarq_pkg::ST_OK)) |->
      (out_ready_thread == '0 && out_woken_count == '0))
    else $error("non-ok result carries thread or wake count");

  // full is only reported with the queue at capacity
  a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == iarq_pkg::ST_FULL)) |-> (out_occupancy == OCC_FULL))
    else $error("full status with queue below capacity");

endmodule

bind io_aware_ready_queue iarq_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_iarq_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_status       (out_ch.status),
  .out_ready_thread (out_ch.ready_thread),
  .out_woken_count  (out_ch.woken_count),
  .out_occupancy    (out_ch.occupancy)
);

// File: bench/tb_io_aware_ready_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_io_aware_ready_queue: self-checking bench for the io-aware ready queue
// drives push, remove, peek and wake words over the input channel, mirrors the
// sorted slot array in a scoreboard and checks every result word in order
// ----------------------------------------------------------------------------
module tb_io_aware_ready_queue;

  localparam int unsigned DEPTH       = 16;
  localparam int unsigned RAND_WORDS  = 300;       // per idling phase
  localparam int unsigned TAIL_CYCLES = 10;        // idle tail after the last drain
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned LONG_HOLD   = 120;       // receiver hold-off, in cycles
  localparam int unsigned HOLD_AFTER  = 150;       // words noted before the hold-off
  localparam int unsigned MAX_REPORTS = 10;

  // idle percentages per phase: receiver slow side first, then sender, then none
  localparam int unsigned SEND_IDLE [3] = '{17, 64, 0};
  localparam int unsigned RECV_IDLE [3] = '{64, 17, 0};
  // push share of the random mix, redrawn every few dozen words so the
  // occupancy swings between empty and full
  localparam int unsigned PUSH_MIX [3] = '{25, 50, 75};

  typedef struct packed {
    iarq_pkg::op_t              func;
    logic [iarq_pkg::TID_W-1:0] thread_id;
    logic [iarq_pkg::PRI_W-1:0] priority_req;
    logic                       waiting;
    logic [iarq_pkg::DEV_W-1:0] device;
  } op_word_t;

  typedef struct packed {
    iarq_pkg::status_t          status;
    logic [iarq_pkg::TID_W-1:0] ready_thread;
    logic [iarq_pkg::CNT_W-1:0] woken_count;
    logic [iarq_pkg::CNT_W-1:0] occupancy;
  } result_word_t;

  // mirror of the slot array plus the in-order list of result words still owed
  class queue_scoreboard;
    logic [iarq_pkg::TID_W-1:0] mirror_thread [DEPTH];
    logic [iarq_pkg::PRI_W-1:0] mirror_prio [DEPTH];
    logic                       mirror_wait [DEPTH];
    logic [iarq_pkg::DEV_W-1:0] mirror_dev [DEPTH];
    int unsigned      mirror_count;
    result_word_t     expected_words [$];
    int unsigned      errors;
    int unsigned      words_noted;
    int unsigned      words_checked;
    int unsigned      full_seen;
    int unsigned      miss_seen;
    int unsigned      ops_seen [4];

    function new();
      mirror_count  = 0;
      errors        = 0;
      words_noted   = 0;
      words_checked = 0;
      full_seen     = 0;
      miss_seen     = 0;
      ops_seen      = '{0, 0, 0, 0};
    endfunction

    // apply one operation to the mirror and return the result it owes
    function result_word_t schedule_op(op_word_t w);
      result_word_t r;
      int unsigned  pos;
      int unsigned  k;
      int unsigned  woken;
      bit           hit;
      r.status       = iarq_pkg::ST_OK;
      r.ready_thread = '0;
      woken          = 0;
      hit            = 1'b0;
      case (w.func)
        iarq_pkg::OP_PUSH: begin
          if (mirror_count >= DEPTH) begin
            r.status = iarq_pkg::ST_FULL;
          end else begin
            // goes behind every entry of equal or higher priority
            pos = 0;
            while (pos < mirror_count && mirror_prio[pos] >= w.priority_req) pos++;
            for (k = mirror_count; k > pos; k--) begin
              mirror_thread[k] = mirror_thread[k-1];
              mirror_prio[k]   = mirror_prio[k-1];
              mirror_wait[k]   = mirror_wait[k-1];
              mirror_dev[k]    = mirror_dev[k-1];
            end
            mirror_thread[pos] = w.thread_id;
            mirror_prio[pos]   = w.priority_req;
            mirror_wait[pos]   = w.waiting;
            mirror_dev[pos]    = w.device;
            mirror_count++;
          end
        end
        iarq_pkg::OP_REMOVE: begin
          // only the first matching entry in queue order goes
          for (pos = 0; pos < mirror_count; pos++) begin
            if (!hit && mirror_thread[pos] == w.thread_id) begin
              hit = 1'b1;
              for (k = pos; k + 1 < mirror_count; k++) begin
                mirror_thread[k] = mirror_thread[k+1];
                mirror_prio[k]   = mirror_prio[k+1];
                mirror_wait[k]   = mirror_wait[k+1];
                mirror_dev[k]    = mirror_dev[k+1];
              end
            end
          end
          if (hit) mirror_count--;
          else r.status = iarq_pkg::ST_MISS;
        end
        iarq_pkg::OP_PEEK: begin
          for (k = 0; k < mirror_count; k++) begin
            if (!hit && !mirror_wait[k]) begin
              hit            = 1'b1;
              r.ready_thread = mirror_thread[k];
            end
          end
          if (!hit) r.status = iarq_pkg::ST_MISS;
        end
        default: begin
          if (mirror_count == 0) begin
            r.status = iarq_pkg::ST_MISS;
          end else begin
            for (k = 0; k < mirror_count; k++) begin
              if (mirror_wait[k] && mirror_dev[k] == w.device) begin
                mirror_wait[k] = 1'b0;
                woken++;
              end
            end
          end
        end
      endcase
      r.woken_count = woken[iarq_pkg::CNT_W-1:0];
      r.occupancy   = mirror_count[iarq_pkg::CNT_W-1:0];
      return r;
    endfunction

    function void note_op(op_word_t w);
      result_word_t r;
      r = schedule_op(w);
      words_noted++;
      ops_seen[w.func]++;
      if (r.status == iarq_pkg::ST_FULL) full_seen++;
      if (r.status == iarq_pkg::ST_MISS) miss_seen++;
      expected_words.push_back(r);
    endfunction

    function void check_word(result_word_t got);
      result_word_t want;
      if (expected_words.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected result word: status %0d thread %0d woken %0d occupancy %0d",
                   got.status, got.ready_thread, got.woken_count, got.occupancy);
        return;
      end
      want = expected_words.pop_front();
      words_checked++;
      if (got.status !== want.status || got.ready_thread !== want.ready_thread ||
          got.woken_count !== want.woken_count || got.occupancy !== want.occupancy) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $write("mismatch on word %0d: expected status %0d thread %0d woken %0d ",
                 words_checked, want.status, want.ready_thread, want.woken_count);
          $display("occupancy %0d, got status %0d thread %0d woken %0d occupancy %0d",
                   want.occupancy, got.status, got.ready_thread, got.woken_count,
                   got.occupancy);
        end
      end
    endfunction

    function int unsigned pending();
      return expected_words.size();
    endfunction

    // a thread id that is in the queue right now, so removes often hit
    function logic [iarq_pkg::TID_W-1:0] live_thread();
      if (mirror_count == 0) return '0;
      return mirror_thread[$urandom_range(mirror_count - 1)];
    endfunction

    // a device some live entry names, so wakes often find waiters
    function logic [iarq_pkg::DEV_W-1:0] live_device();
      if (mirror_count == 0) return '0;
      return mirror_dev[$urandom_range(mirror_count - 1)];
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  int   phase = 0;
  int unsigned cycle_count = 0;

  iarq_in_if  in_ch ();
  iarq_out_if out_ch ();

  queue_scoreboard sb = new();

  io_aware_ready_queue #(
    .QUEUE_DEPTH(DEPTH)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog: a hung handshake ends the run here
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic op_word_t pack_op(iarq_pkg::op_t f, int unsigned tid, int unsigned pri,
                                       bit w, int unsigned dev);
    op_word_t o;
    o.func         = f;
    o.thread_id    = tid[iarq_pkg::TID_W-1:0];
    o.priority_req = pri[iarq_pkg::PRI_W-1:0];
    o.waiting      = w;
    o.device       = dev[iarq_pkg::DEV_W-1:0];
    return o;
  endfunction

  // offer one word, with random idle cycles ahead of it, and note it once taken
  task automatic send_op(op_word_t w);
    while ($urandom_range(99) < SEND_IDLE[phase]) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.func         <= w.func;
    in_ch.thread_id    <= w.thread_id;
    in_ch.priority_req <= w.priority_req;
    in_ch.waiting      <= w.waiting;
    in_ch.device       <= w.device;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_op(w);
  endtask

  // sender pause: hold valid low until every owed result word is back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic run_random(int unsigned count);
    op_word_t    w;
    int unsigned push_pct;
    int unsigned roll;
    push_pct = PUSH_MIX[1];
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 40 == 0) push_pct = PUSH_MIX[$urandom_range(2)];
      roll = $urandom_range(99);
      if (roll < push_pct) begin
        w.func = iarq_pkg::OP_PUSH;
      end else begin
        roll = $urandom_range(9);
        if (roll < 4)      w.func = iarq_pkg::OP_REMOVE;
        else if (roll < 7) w.func = iarq_pkg::OP_PEEK;
        else               w.func = iarq_pkg::OP_WAKE;
      end
      // small id and device pools make duplicates and matches common;
      // full-range draws keep every payload bit moving
      w.thread_id    = ($urandom_range(3) == 0) ? iarq_pkg::TID_W'($urandom)
                                                : iarq_pkg::TID_W'($urandom_range(7));
      w.priority_req = ($urandom_range(1) == 0) ? iarq_pkg::PRI_W'($urandom)
                                                : iarq_pkg::PRI_W'($urandom_range(3));
      w.waiting      = 1'($urandom_range(1));
      w.device       = ($urandom_range(2) == 0) ? iarq_pkg::DEV_W'($urandom)
                                                : iarq_pkg::DEV_W'($urandom_range(3));
      if (w.func == iarq_pkg::OP_REMOVE && $urandom_range(3) != 0)
        w.thread_id = sb.live_thread();
      if (w.func == iarq_pkg::OP_WAKE && $urandom_range(1) != 0)
        w.device = sb.live_device();
      send_op(w);
    end
  endtask

  // result side: check accepted words, then pick ready for the next cycle
  initial begin
    result_word_t got;
    int unsigned  hold_left;
    bit           long_hold_done;
    hold_left      = 0;
    long_hold_done = 1'b0;
    out_ch.ready  <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (out_ch.valid && out_ch.ready) begin
        got.status       = iarq_pkg::status_t'(out_ch.status);
        got.ready_thread = out_ch.ready_thread;
        got.woken_count  = out_ch.woken_count;
        got.occupancy    = out_ch.occupancy;
        sb.check_word(got);
      end
      // one long hold-off while the sender keeps offering, so the block backs up
      if (!long_hold_done && sb.words_noted >= HOLD_AFTER) begin
        hold_left      = LONG_HOLD;
        long_hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= RECV_IDLE[phase]);
      end
      @(posedge clk);
    end
  end

  // stimulus
  initial begin
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.func         <= iarq_pkg::OP_PUSH;
    in_ch.thread_id    <= '0;
    in_ch.priority_req <= '0;
    in_ch.waiting      <= 1'b0;
    in_ch.device       <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty queue: peek, wake and remove all miss
    send_op(pack_op(iarq_pkg::OP_PEEK, 0, 0, 0, 0));
    send_op(pack_op(iarq_pkg::OP_WAKE, 0, 0, 0, 0));
    send_op(pack_op(iarq_pkg::OP_REMOVE, 0, 0, 0, 0));
    // field extremes, both entries waiting so peek finds none ready
    send_op(pack_op(iarq_pkg::OP_PUSH, 255, 255, 1, 255));
    send_op(pack_op(iarq_pkg::OP_PUSH, 0, 0, 1, 0));
    send_op(pack_op(iarq_pkg::OP_PEEK, 0, 0, 0, 0));
    // wake with no matching device still reports ok, then a real wake
    send_op(pack_op(iarq_pkg::OP_WAKE, 0, 0, 0, 7));
    send_op(pack_op(iarq_pkg::OP_WAKE, 0, 0, 0, 255));
    send_op(pack_op(iarq_pkg::OP_PEEK, 0, 0, 0, 0));
    // equal priorities keep arrival order, duplicate ids are accepted
    send_op(pack_op(iarq_pkg::OP_PUSH, 10, 128, 0, 1));
    send_op(pack_op(iarq_pkg::OP_PUSH, 11, 128, 0, 1));
    send_op(pack_op(iarq_pkg::OP_PUSH, 10, 200, 1, 1));
    // remove takes only the first id 10 in queue order
    send_op(pack_op(iarq_pkg::OP_REMOVE, 10, 0, 0, 0));
    // fill to the brim, then one push too many
    for (int unsigned i = 0; i < 12; i++)
      send_op(pack_op(iarq_pkg::OP_PUSH, 20 + i, i * 23, i[0], i % 3));
    send_op(pack_op(iarq_pkg::OP_PUSH, 99, 77, 0, 9));
    send_op(pack_op(iarq_pkg::OP_WAKE, 0, 0, 0, 1));
    send_op(pack_op(iarq_pkg::OP_REMOVE, 99, 0, 0, 0));

    // random traffic under each idling pattern, draining between phases
    run_random(RAND_WORDS);
    drain_results();
    phase = 1;
    run_random(RAND_WORDS);
    drain_results();
    phase = 2;
    run_random(RAND_WORDS);
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("checked %0d result words: %0d push, %0d remove, %0d peek, %0d wake",
             sb.words_checked, sb.ops_seen[iarq_pkg::OP_PUSH],
             sb.ops_seen[iarq_pkg::OP_REMOVE], sb.ops_seen[iarq_pkg::OP_PEEK],
             sb.ops_seen[iarq_pkg::OP_WAKE]);
    $display("pushes refused when full: %0d, misses: %0d, mismatches: %0d",
             sb.full_seen, sb.miss_seen, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
